// File: src/mme_pkg.sv
package mme_pkg;

	// Fixed field widths of the channels and the product, and the number of fraction bits.
	localparam int IDX_W = 6;
	localparam int CFG_W = 7;
	localparam int Q_W = 16;
	localparam int PROD_W = 2 * Q_W;
	localparam int FRAC_BITS = 12;

	// Q4.12 clamp limits.
	localparam int Q_MAX = 32767;
	localparam int Q_MIN = -32768;

	// Operation codes of an input item.
	localparam logic [1:0] OP_LOAD_A = 2'd0;
	localparam logic [1:0] OP_LOAD_B = 2'd1;
	localparam logic [1:0] OP_COMPUTE = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_A_ROWS = 2'd0;
	localparam logic [1:0] REG_A_COLS = 2'd1;
	localparam logic [1:0] REG_B_ROWS = 2'd2;
	localparam logic [1:0] REG_B_COLS = 2'd3;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FIN
	} state_t;

	// Control from the sequencer to the multiply-accumulate unit.
	typedef struct packed {
		logic clr;
		logic vld;
	} mac_ctrl_t;

endpackage

// File: src/mme_ram.sv
module mme_ram #(
	parameter int DEPTH = 4096,
	parameter int ADDR_W = 12,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/mme_mac.sv
module mme_mac #(
	parameter int ACC_W = 39
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mme_pkg::mac_ctrl_t          ctrl,
	input  logic [mme_pkg::Q_W-1:0]     a_data,
	input  logic [mme_pkg::Q_W-1:0]     b_data,
	output logic                        busy,
	output logic [mme_pkg::Q_W-1:0]     q_value,
	output logic                        q_sat
);

	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(mme_pkg::Q_MAX);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(mme_pkg::Q_MIN);

	logic signed [mme_pkg::PROD_W-1:0] prod_s2;
	logic                              prod_vld_s2;
	logic signed [ACC_W-1:0]           acc_q;
	logic signed [ACC_W-1:0]           shifted;

	// Valid flag of the product stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s2 <= 1'b0;
		end else begin
			prod_vld_s2 <= ctrl.vld;
		end
	end

	// Exact product, then full-width accumulation.
	always_ff @(posedge clk) begin
		prod_s2 <= $signed(a_data) * $signed(b_data);
		if (ctrl.clr) begin
			acc_q <= '0;
		end else if (prod_vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	assign busy = prod_vld_s2;

	// Drop the fraction bits (floor), then clamp to the Q4.12 range.
	always_comb begin
		shifted = acc_q >>> mme_pkg::FRAC_BITS;
		if (shifted > SAT_HI) begin
			q_value = mme_pkg::Q_W'(mme_pkg::Q_MAX);
			q_sat = 1'b1;
		end else if (shifted < SAT_LO) begin
			q_value = mme_pkg::Q_W'(mme_pkg::Q_MIN);
			q_sat = 1'b1;
		end else begin
			q_value = shifted[mme_pkg::Q_W-1:0];
			q_sat = 1'b0;
		end
	end

endmodule

// File: src/matrix_multiply_engine_core.sv
// Channel   Handshake              Payload
// in        in_valid / in_stall    op, row_index, col_index, elem_value
// out       out_valid / out_stall  res_row, res_col, res_value, saturated, shape_error
// cfg       cfg_we                 cfg_index, cfg_data
//
// A load does not hold off the input: the next item can be taken in the following cycle.
// A compute runs through the accepting cycle, one read of each store per cycle through its
// single read port, the read, product and accumulate registers, and the load of the
// output register. A shape mismatch skips the reads and goes straight to the output
// register; an ignored request produces no result.
// Reset clears the control state and sets the dimension registers to 1; store contents stay
// undefined until loaded. A stalled output holds its beat, and a finished compute
// waits for the output register before new items are taken.
module matrix_multiply_engine_core #(
	parameter int MAX_DIM = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [mme_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    op,
	input  logic [mme_pkg::IDX_W-1:0]     row_index,
	input  logic [mme_pkg::IDX_W-1:0]     col_index,
	input  logic signed [mme_pkg::Q_W-1:0] elem_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mme_pkg::IDX_W-1:0]     res_row,
	output logic [mme_pkg::IDX_W-1:0]     res_col,
	output logic signed [mme_pkg::Q_W-1:0] res_value,
	output logic                          saturated,
	output logic                          shape_error
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(MAX_DIM + 1);
	localparam int EXT_W = (CNT_W > mme_pkg::CFG_W) ? CNT_W : mme_pkg::CFG_W;
	localparam int ACC_W = mme_pkg::PROD_W + CNT_W;

	mme_pkg::state_t state_q, state_d;

	logic [mme_pkg::CFG_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	logic [EXT_W-1:0]          ar_eff, ac_eff, br_eff, bc_eff;
	logic [CNT_W-1:0]          j_q;
	logic [mme_pkg::IDX_W-1:0] r_q, c_q;
	logic                      shape_q;
	logic                      issue, issue_s1;
	logic                      accept, load_ok, cmp_ok, last_issue, out_load;
	logic                      a_we, b_we;
	logic [ADDR_W-1:0]         waddr, a_raddr, b_raddr;
	logic [mme_pkg::Q_W-1:0]   a_rdata, b_rdata, q_value;
	logic                      q_sat, mac_busy;
	mme_pkg::mac_ctrl_t        mac_ctrl;

	// Out-of-range dimension registers are clamped to 1..MAX_DIM.
	function automatic logic [EXT_W-1:0] eff_dim(input logic [mme_pkg::CFG_W-1:0] v);
		logic [EXT_W-1:0] ext;
		ext = EXT_W'(v);
		if (ext == '0) begin
			return EXT_W'(1);
		end else if (ext > EXT_W'(MAX_DIM)) begin
			return EXT_W'(MAX_DIM);
		end
		return ext;
	endfunction

	// Dimension registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= mme_pkg::CFG_W'(1);
			a_cols_q <= mme_pkg::CFG_W'(1);
			b_rows_q <= mme_pkg::CFG_W'(1);
			b_cols_q <= mme_pkg::CFG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				mme_pkg::REG_A_ROWS: a_rows_q <= cfg_data;
				mme_pkg::REG_A_COLS: a_cols_q <= cfg_data;
				mme_pkg::REG_B_ROWS: b_rows_q <= cfg_data;
				mme_pkg::REG_B_COLS: b_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign ar_eff = eff_dim(a_rows_q);
	assign ac_eff = eff_dim(a_cols_q);
	assign br_eff = eff_dim(b_rows_q);
	assign bc_eff = eff_dim(b_cols_q);

	// Position checks and store addresses.
	assign accept = in_valid && !in_stall;
	assign load_ok = (EXT_W'(row_index) < EXT_W'(MAX_DIM)) &&
			(EXT_W'(col_index) < EXT_W'(MAX_DIM));
	assign cmp_ok = (EXT_W'(row_index) < ar_eff) && (EXT_W'(col_index) < bc_eff);
	assign a_we = accept && (op == mme_pkg::OP_LOAD_A) && load_ok;
	assign b_we = accept && (op == mme_pkg::OP_LOAD_B) && load_ok;
	assign waddr = ADDR_W'(32'(row_index) * MAX_DIM + 32'(col_index));
	assign a_raddr = ADDR_W'(32'(r_q) * MAX_DIM + 32'(j_q));
	assign b_raddr = ADDR_W'(32'(j_q) * MAX_DIM + 32'(c_q));
	assign last_issue = (EXT_W'(j_q) == ac_eff - EXT_W'(1));

	// Sequencer next state and strobes.
	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		issue = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			mme_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && op == mme_pkg::OP_COMPUTE) begin
					if (ac_eff != br_eff) begin
						state_d = mme_pkg::ST_FIN;
					end else if (cmp_ok) begin
						state_d = mme_pkg::ST_RUN;
					end
				end
			end
			mme_pkg::ST_RUN: begin
				issue = 1'b1;
				if (last_issue) begin
					state_d = mme_pkg::ST_DRAIN;
				end
			end
			mme_pkg::ST_DRAIN: begin
				if (!issue_s1 && !mac_busy) begin
					state_d = mme_pkg::ST_FIN;
				end
			end
			mme_pkg::ST_FIN: begin
				if (!out_valid || !out_stall) begin
					out_load = 1'b1;
					state_d = mme_pkg::ST_IDLE;
				end
			end
			default: state_d = mme_pkg::ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mme_pkg::ST_IDLE;
			issue_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			issue_s1 <= issue;
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Request registers, inner counter and output beat.
	always_ff @(posedge clk) begin
		if (accept && op == mme_pkg::OP_COMPUTE) begin
			r_q <= row_index;
			c_q <= col_index;
			shape_q <= (ac_eff != br_eff);
			j_q <= '0;
		end else if (issue) begin
			j_q <= j_q + CNT_W'(1);
		end
		if (out_load) begin
			res_row <= r_q;
			res_col <= c_q;
			res_value <= shape_q ? '0 : q_value;
			saturated <= shape_q ? 1'b0 : q_sat;
			shape_error <= shape_q;
		end
	end

	assign mac_ctrl.clr = accept && (op == mme_pkg::OP_COMPUTE);
	assign mac_ctrl.vld = issue_s1;

	mme_ram #(
		.DEPTH(DEPTH),
		.ADDR_W(ADDR_W),
		.DATA_W(mme_pkg::Q_W)
	) u_a_store (
		.clk(clk),
		.we(a_we),
		.waddr(waddr),
		.wdata(elem_value),
		.re(issue),
		.raddr(a_raddr),
		.rdata(a_rdata)
	);

	mme_ram #(
		.DEPTH(DEPTH),
		.ADDR_W(ADDR_W),
		.DATA_W(mme_pkg::Q_W)
	) u_b_store (
		.clk(clk),
		.we(b_we),
		.waddr(waddr),
		.wdata(elem_value),
		.re(issue),
		.raddr(b_raddr),
		.rdata(b_rdata)
	);

	mme_mac #(
		.ACC_W(ACC_W)
	) u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(mac_ctrl),
		.a_data(a_rdata),
		.b_data(b_rdata),
		.busy(mac_busy),
		.q_value(q_value),
		.q_sat(q_sat)
	);

endmodule

// File: src/mme_checker.sv
module mme_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic [1:0]                     op,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [mme_pkg::IDX_W-1:0]      res_row,
	input logic [mme_pkg::IDX_W-1:0]      res_col,
	input logic signed [mme_pkg::Q_W-1:0] res_value,
	input logic                           saturated,
	input logic                           shape_error
);

	// A stalled result beat stays up and unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(res_row) && $stable(res_col) &&
			$stable(res_value) && $stable(saturated) && $stable(shape_error))
	else $error("stalled result beat changed");

	// Loads never hold off the following item.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (op == mme_pkg::OP_LOAD_A || op == mme_pkg::OP_LOAD_B)
			|=> !in_stall)
	else $error("input stalled after a load");

	// A shape error carries a zero value and no clamp flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && shape_error |-> res_value == '0 && !saturated)
	else $error("shape error with nonzero result");

	// A clamped value sits at one of the range limits.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> res_value == 16'sh7FFF || res_value == 16'sh8000)
	else $error("saturated value not at a limit");

endmodule

bind matrix_multiply_engine_core mme_checker u_mme_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.op(op),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.res_row(res_row),
	.res_col(res_col),
	.res_value(res_value),
	.saturated(saturated),
	.shape_error(shape_error)
);
